@@ hdl/fcmaf_pkg.sv @@
package fcmaf_pkg;

  localparam int WINDOW_DEPTH = 16;
  localparam int NUM_CHAN     = 4;
  localparam int CHAN_W       = 16;
  localparam int ROW_W        = NUM_CHAN * CHAN_W;
  localparam int BYTE_W       = 8;
  localparam int FRAME_LEN    = 10;
  localparam int CHAN_MAX     = 65535;

  localparam logic [BYTE_W-1:0] FRAME_HEADER = 8'h5A;

  // Floor of log2; the window sum is scaled down by this many bits.
  function automatic int floor_log2(input int v);
    int s;
    s = 0;
    for (int i = 0; i < 31; i++) begin
      if ((v >> (i + 1)) != 0) begin
        s = i + 1;
      end
    end
    return s;
  endfunction

  localparam int SHIFT = floor_log2(WINDOW_DEPTH);
  localparam int SUM_W = $clog2(WINDOW_DEPTH * CHAN_MAX + 1);
  localparam int PTR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W = $clog2(FRAME_LEN);

  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [SUM_W-1:0]  sum_t;
  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [BYTE_W-1:0] byte_t;

  localparam ptr_t PTR_LAST = ptr_t'(WINDOW_DEPTH - 1);
  localparam cnt_t CNT_HEAD = cnt_t'(0);
  localparam cnt_t CNT_SUM  = cnt_t'(FRAME_LEN - 1);

endpackage

@@ hdl/four_channel_moving_average_framer_top.sv @@
// Channel   Dir  Width  Content
// s_axis    in   64     one measurement per transaction
// m_axis    out  8      one frame byte per transaction, tlast on the checksum
//
// Each measurement yields ten output transactions, so the sustained measurement
// rate is set by the byte-wide output channel.
// A measurement passes the input stage and then the average and frame registers before its header byte is offered.
// The history sits in a ring memory with a registered read; running sums are
// updated by adding the new row and subtracting the row it overwrites.
// Reset clears the running sums and the per-entry valid bits at once.
// One measurement waits in the input stage while a frame is sent.
module four_channel_moving_average_framer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // width_x, period_x, width_y, period_y
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // frame_byte
  output logic        m_axis_tlast   // frame_last
);

  fcmaf_pkg::row_t  mem [fcmaf_pkg::WINDOW_DEPTH];
  logic [fcmaf_pkg::WINDOW_DEPTH-1:0] vld;

  fcmaf_pkg::ptr_t  wp;
  fcmaf_pkg::ptr_t  ptr1;
  logic             valid1;
  fcmaf_pkg::row_t  data1;
  fcmaf_pkg::row_t  rd_data;
  logic             rd_vld;
  fcmaf_pkg::row_t  old_row;

  fcmaf_pkg::sum_t  sum      [fcmaf_pkg::NUM_CHAN];
  fcmaf_pkg::sum_t  sum_next [fcmaf_pkg::NUM_CHAN];
  fcmaf_pkg::row_t  avg;
  fcmaf_pkg::row_t  avg_next;

  logic             fvalid;
  fcmaf_pkg::cnt_t  cnt;
  fcmaf_pkg::byte_t cc;
  fcmaf_pkg::byte_t frame_byte;
  logic [2:0]       byte_idx;

  logic accept;
  logic adv;
  logic out_hs;
  logic frame_done;

  assign out_hs     = fvalid & m_axis_tready;
  assign frame_done = out_hs & (cnt == fcmaf_pkg::CNT_SUM);
  assign adv        = valid1 & (~fvalid | frame_done);
  assign s_axis_tready = ~valid1 | adv;
  assign accept     = s_axis_tvalid & s_axis_tready;

  assign old_row = rd_vld ? rd_data : '0;

  always_comb begin
    for (int c = 0; c < fcmaf_pkg::NUM_CHAN; c++) begin
      sum_next[c] = sum[c]
                  + fcmaf_pkg::sum_t'(data1[c*fcmaf_pkg::CHAN_W +: fcmaf_pkg::CHAN_W])
                  - fcmaf_pkg::sum_t'(old_row[c*fcmaf_pkg::CHAN_W +: fcmaf_pkg::CHAN_W]);
      avg_next[c*fcmaf_pkg::CHAN_W +: fcmaf_pkg::CHAN_W] =
        sum_next[c][fcmaf_pkg::SHIFT +: fcmaf_pkg::CHAN_W];
    end
  end

  // Ring memory: read at the entry about to be overwritten, write on advance.
  always_ff @(posedge clk) begin
    if (adv) begin
      mem[ptr1] <= data1;
    end
    if (accept) begin
      if (adv && (ptr1 == wp)) begin
        rd_data <= data1;
      end else begin
        rd_data <= mem[wp];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      wp     <= '0;
      valid1 <= 1'b0;
      rd_vld <= 1'b0;
      for (int c = 0; c < fcmaf_pkg::NUM_CHAN; c++) begin
        sum[c] <= '0;
      end
    end else begin
      if (adv) begin
        vld[ptr1] <= 1'b1;
        for (int c = 0; c < fcmaf_pkg::NUM_CHAN; c++) begin
          sum[c] <= sum_next[c];
        end
      end
      if (accept) begin
        valid1 <= 1'b1;
        rd_vld <= vld[wp] | (adv && (ptr1 == wp));
        wp     <= (wp == fcmaf_pkg::PTR_LAST) ? '0 : wp + fcmaf_pkg::ptr_t'(1);
      end else if (adv) begin
        valid1 <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data1 <= s_axis_tdata;
      ptr1  <= wp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fvalid <= 1'b0;
      cnt    <= fcmaf_pkg::CNT_HEAD;
    end else if (adv) begin
      fvalid <= 1'b1;
      cnt    <= fcmaf_pkg::CNT_HEAD;
    end else if (frame_done) begin
      fvalid <= 1'b0;
    end else if (out_hs) begin
      cnt <= cnt + fcmaf_pkg::cnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      avg <= avg_next;
      cc  <= fcmaf_pkg::FRAME_HEADER;
    end else if (out_hs && (cnt != fcmaf_pkg::CNT_HEAD)) begin
      cc <= cc + frame_byte;
    end
  end

  assign byte_idx = 3'(cnt - fcmaf_pkg::cnt_t'(1));

  always_comb begin
    case (cnt)
      fcmaf_pkg::CNT_HEAD: frame_byte = fcmaf_pkg::FRAME_HEADER;
      fcmaf_pkg::CNT_SUM:  frame_byte = cc;
      default:             frame_byte = avg[byte_idx*fcmaf_pkg::BYTE_W +: fcmaf_pkg::BYTE_W];
    endcase
  end

  assign m_axis_tvalid = fvalid;
  assign m_axis_tdata  = frame_byte;
  assign m_axis_tlast  = fvalid & (cnt == fcmaf_pkg::CNT_SUM);

`ifndef SYNTHESIS
  a_load_starts_frame: assert property (@(posedge clk) disable iff (rst)
    adv |=> (fvalid && (cnt == fcmaf_pkg::CNT_HEAD)))
    else $error("frame did not restart at the header after a load");

  a_cnt_in_range: assert property (@(posedge clk) disable iff (rst)
    fvalid |-> (cnt <= fcmaf_pkg::CNT_SUM))
    else $error("frame byte counter out of range");

  a_written_valid: assert property (@(posedge clk) disable iff (rst)
    adv |=> vld[$past(ptr1)])
    else $error("history entry not marked valid after write");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    (valid1 && !adv) |=> valid1)
    else $error("pending measurement lost without advancing");
`endif

endmodule

@@ tb/sv/maf_frame_checker.sv @@
`timescale 1ns / 1ps

module maf_frame_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,
  input  logic        m_axis_tlast,
  output int          mismatches,
  output int          bytes_due
);

  typedef struct packed {
    fcmaf_pkg::byte_t data;
    logic             last;
  } frame_beat_t;

  fcmaf_pkg::chan_t window_rows [fcmaf_pkg::WINDOW_DEPTH][fcmaf_pkg::NUM_CHAN];
  frame_beat_t      beats_due[$];

  initial begin
    mismatches = 0;
    bytes_due  = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic push_beat(input fcmaf_pkg::byte_t data, input logic last);
    frame_beat_t beat;
    beat.data = data;
    beat.last = last;
    beats_due.push_back(beat);
  endtask

  // The newest measurement enters at row 0 and the oldest row drops out.
  task automatic predict_frame(input logic [63:0] meas);
    fcmaf_pkg::sum_t  total;
    fcmaf_pkg::chan_t avg;
    fcmaf_pkg::byte_t csum;
    for (int k = fcmaf_pkg::WINDOW_DEPTH - 1; k > 0; k--) begin
      for (int c = 0; c < fcmaf_pkg::NUM_CHAN; c++) begin
        window_rows[k][c] = window_rows[k-1][c];
      end
    end
    for (int c = 0; c < fcmaf_pkg::NUM_CHAN; c++) begin
      window_rows[0][c] = meas[c*fcmaf_pkg::CHAN_W +: fcmaf_pkg::CHAN_W];
    end
    push_beat(fcmaf_pkg::FRAME_HEADER, 1'b0);
    csum = fcmaf_pkg::FRAME_HEADER;
    for (int c = 0; c < fcmaf_pkg::NUM_CHAN; c++) begin
      total = '0;
      for (int k = 0; k < fcmaf_pkg::WINDOW_DEPTH; k++) begin
        total = total + fcmaf_pkg::sum_t'(window_rows[k][c]);
      end
      avg  = fcmaf_pkg::chan_t'(total >> fcmaf_pkg::SHIFT);
      push_beat(avg[7:0], 1'b0);
      push_beat(avg[15:8], 1'b0);
      csum = csum + avg[7:0] + avg[15:8];
    end
    push_beat(csum, 1'b1);
  endtask

  always @(posedge clk) begin
    frame_beat_t want;
    if (rst) begin
      beats_due.delete();
      for (int k = 0; k < fcmaf_pkg::WINDOW_DEPTH; k++) begin
        for (int c = 0; c < fcmaf_pkg::NUM_CHAN; c++) begin
          window_rows[k][c] = '0;
        end
      end
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (beats_due.size() == 0) begin
          report_mismatch($sformatf("unexpected frame byte 0x%02h last %0b",
                                    m_axis_tdata, m_axis_tlast));
        end else begin
          want = beats_due.pop_front();
          if (m_axis_tdata !== want.data) begin
            report_mismatch($sformatf("frame_byte expected 0x%02h got 0x%02h",
                                      want.data, m_axis_tdata));
          end
          if (m_axis_tlast !== want.last) begin
            report_mismatch($sformatf("frame_last expected %0b got %0b",
                                      want.last, m_axis_tlast));
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_frame(s_axis_tdata);
      end
    end
    bytes_due = beats_due.size();
  end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  int          mismatches;
  int          bytes_due;
  int          src_idle = 0;
  int          dst_stall = 0;

  four_channel_moving_average_framer_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  maf_frame_checker frame_check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .mismatches    (mismatches),
    .bytes_due     (bytes_due)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= dst_stall);
  end

  function automatic fcmaf_pkg::row_t pack_meas(input fcmaf_pkg::chan_t wx,
                                                input fcmaf_pkg::chan_t px,
                                                input fcmaf_pkg::chan_t wy,
                                                input fcmaf_pkg::chan_t py);
    return {py, wy, px, wx};
  endfunction

  function automatic fcmaf_pkg::chan_t pick_value(input int mode);
    case (mode)
      5, 6:    return fcmaf_pkg::chan_t'(fcmaf_pkg::CHAN_MAX - $urandom_range(15));
      7:       return fcmaf_pkg::chan_t'($urandom_range(15));
      8:       return fcmaf_pkg::chan_t'(fcmaf_pkg::CHAN_MAX);
      9:       return '0;
      default: return fcmaf_pkg::chan_t'($urandom_range(fcmaf_pkg::CHAN_MAX));
    endcase
  endfunction

  task automatic send_meas(input fcmaf_pkg::row_t meas);
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= meas;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic send_random_meas();
    int mode;
    mode = $urandom_range(9);
    send_meas(pack_meas(pick_value(mode), pick_value(mode),
                        pick_value(mode), pick_value(mode)));
  endtask

  initial begin
    int mode;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_meas(pack_meas(16'h0001, 16'h0002, 16'h8000, 16'hFFFF));
    send_meas(pack_meas(16'h0000, 16'h0000, 16'h0000, 16'h0000));
    repeat (fcmaf_pkg::WINDOW_DEPTH) begin
      send_meas(pack_meas(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    end
    send_meas(pack_meas(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555));
    send_meas(pack_meas(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA));
    send_meas(pack_meas(16'h0000, 16'h0000, 16'h0000, 16'h0000));

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle = 0;  dst_stall <= 0;  end
        1: begin src_idle = 75; dst_stall <= 0;  end
        2: begin src_idle = 0;  dst_stall <= 75; end
        default: begin src_idle = 36; dst_stall <= 36; end
      endcase
      for (int n = 0; n < 67; n++) begin
        if ($urandom_range(29) == 0) begin
          mode = 5 + $urandom_range(3);
          for (int k = 0; k < fcmaf_pkg::WINDOW_DEPTH; k++) begin
            send_meas(pack_meas(pick_value(mode), pick_value(mode),
                                pick_value(mode), pick_value(mode)));
          end
        end else begin
          send_random_meas();
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (bytes_due != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS four_channel_moving_average_framer_top");
    end else begin
      $display("FAIL four_channel_moving_average_framer_top");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("FAIL four_channel_moving_average_framer_top");
    $finish;
  end

endmodule
